/* src/ptd_pkg.sv */
`timescale 1ns / 1ps
// shared widths and types of the point to triangle distance unit
// no dependencies
package ptd_pkg;

	localparam int COORD_BITS    = 16;
	localparam int FRACTION_BITS = 16;
	localparam int DIST_W        = 50;

	// edge and offset vectors
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	// dot products
	localparam int DOT_W   = 2 * DIFF_W + 2;
	localparam int HALF_W  = DOT_W / 2;
	localparam int HI_W    = DOT_W - HALF_W;
	localparam int PP_W    = DOT_W + 2;
	// region determinants and their sums
	localparam int WIDE_W  = 2 * DOT_W + 2;
	localparam int REM_W   = WIDE_W + 1;
	localparam int FRAC_W  = FRACTION_BITS + 1;
	localparam int DIV_LAT = FRACTION_BITS + 1;
	// per-axis residual and its square
	localparam int EF_W     = DIFF_W + FRAC_W + 1;
	localparam int RES_W    = DIFF_W + FRACTION_BITS + 2;
	localparam int SQ_LO_W  = (RES_W + 1) / 2;
	localparam int SQ_HI_W  = RES_W - SQ_LO_W;
	localparam int SPP_W    = RES_W + 2;
	localparam int SQ_W     = 2 * RES_W;
	localparam int SUM_W    = 2 * RES_W + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [DOT_W-1:0]      dot_t;
	typedef logic signed [PP_W-1:0]       pp_t;
	typedef logic signed [WIDE_W-1:0]     wide_t;
	typedef logic [FRAC_W-1:0]            frac_t;
	typedef logic [DIST_W-1:0]            dist_t;

	localparam dist_t DIST_MAX = '1;

	typedef struct packed {
		diff_t [2:0] ab;
		diff_t [2:0] ac;
		diff_t [2:0] bc;
		diff_t [2:0] ap;
		diff_t [2:0] bp;
		diff_t [2:0] cp;
	} geo_t;

	// what the distance stages need besides the two fractions
	typedef struct packed {
		diff_t [2:0] pb;
		diff_t [2:0] e1;
		diff_t [2:0] e2;
		logic        deg;
	} side_t;

endpackage

/* src/ptd_query_if.sv */
`timescale 1ns / 1ps
// query channel: point and triangle vertices with valid/ready
// depends on ptd_pkg
interface ptd_query_if;
	import ptd_pkg::*;
	logic   valid;
	logic   ready;
	coord_t query_x, query_y, query_z;
	coord_t vert_a_x, vert_a_y, vert_a_z;
	coord_t vert_b_x, vert_b_y, vert_b_z;
	coord_t vert_c_x, vert_c_y, vert_c_z;

	modport source (output valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
		vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
	modport sink (input valid, query_x, query_y, query_z, vert_a_x, vert_a_y, vert_a_z,
		vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

/* src/ptd_result_if.sv */
`timescale 1ns / 1ps
// result channel: squared distance and degenerate flag with valid/ready
// depends on ptd_pkg
interface ptd_result_if;
	import ptd_pkg::*;
	logic  valid;
	logic  ready;
	dist_t distance_squared;
	logic  degenerate;

	modport source (output valid, distance_squared, degenerate, input ready);
	modport sink (input valid, distance_squared, degenerate, output ready);
endinterface

/* src/ptd_region.sv */
`timescale 1ns / 1ps
// front pipeline: edge vectors, dot products, region determinants, region pick
// depends on ptd_pkg
module ptd_region (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  ptd_pkg::coord_t [2:0]  p,
	input  ptd_pkg::coord_t [2:0]  a,
	input  ptd_pkg::coord_t [2:0]  b,
	input  ptd_pkg::coord_t [2:0]  c,
	output logic                   out_valid,
	output ptd_pkg::side_t         side,
	output ptd_pkg::wide_t         num1,
	output ptd_pkg::wide_t         den1,
	output ptd_pkg::wide_t         num2,
	output ptd_pkg::wide_t         den2
);
	import ptd_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	geo_t  geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6;
	prod_t prod_s2 [6][3];
	dot_t  d_s3 [6];
	dot_t  d_s4 [6];
	dot_t  d_s5 [6];
	dot_t  d_s6 [6];
	pp_t   hh_s4 [6];
	pp_t   hl_s4 [6];
	pp_t   lh_s4 [6];
	pp_t   ll_s4 [6];
	wide_t m_s5 [6];
	wide_t va_s6, vb_s6, vc_s6;
	side_t side_s7;
	wide_t num1_s7, den1_s7, num2_s7, den2_s7;

	diff_t opl [6][3];
	diff_t opr [6][3];
	dot_t  mx [6];
	dot_t  my [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// operand pairs of the six dot products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			opl[0][i] = geo_s1.ab[i]; opr[0][i] = geo_s1.ap[i];
			opl[1][i] = geo_s1.ac[i]; opr[1][i] = geo_s1.ap[i];
			opl[2][i] = geo_s1.ab[i]; opr[2][i] = geo_s1.bp[i];
			opl[3][i] = geo_s1.ac[i]; opr[3][i] = geo_s1.bp[i];
			opl[4][i] = geo_s1.ab[i]; opr[4][i] = geo_s1.cp[i];
			opl[5][i] = geo_s1.ac[i]; opr[5][i] = geo_s1.cp[i];
		end
	end

	// factor pairs of d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
	always_comb begin
		mx[0] = d_s3[0]; my[0] = d_s3[3];
		mx[1] = d_s3[2]; my[1] = d_s3[1];
		mx[2] = d_s3[4]; my[2] = d_s3[1];
		mx[3] = d_s3[0]; my[3] = d_s3[5];
		mx[4] = d_s3[2]; my[4] = d_s3[5];
		mx[5] = d_s3[4]; my[5] = d_s3[3];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				geo_s1.ab[i] <= diff_t'(b[i]) - diff_t'(a[i]);
				geo_s1.ac[i] <= diff_t'(c[i]) - diff_t'(a[i]);
				geo_s1.bc[i] <= diff_t'(c[i]) - diff_t'(b[i]);
				geo_s1.ap[i] <= diff_t'(p[i]) - diff_t'(a[i]);
				geo_s1.bp[i] <= diff_t'(p[i]) - diff_t'(b[i]);
				geo_s1.cp[i] <= diff_t'(p[i]) - diff_t'(c[i]);
			end
			for (int k = 0; k < 6; k++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s2[k][i] <= opl[k][i] * opr[k][i];
				end
				d_s3[k] <= dot_t'(prod_s2[k][0]) + dot_t'(prod_s2[k][1])
					+ dot_t'(prod_s2[k][2]);
				d_s4[k] <= d_s3[k];
				d_s5[k] <= d_s4[k];
				d_s6[k] <= d_s5[k];
			end
			// split products, high half signed and low half unsigned
			for (int m = 0; m < 6; m++) begin
				hh_s4[m] <= $signed(mx[m][DOT_W-1:HALF_W]) * $signed(my[m][DOT_W-1:HALF_W]);
				hl_s4[m] <= $signed(mx[m][DOT_W-1:HALF_W]) * $signed({1'b0, my[m][HALF_W-1:0]});
				lh_s4[m] <= $signed({1'b0, mx[m][HALF_W-1:0]}) * $signed(my[m][DOT_W-1:HALF_W]);
				ll_s4[m] <= $signed({1'b0, mx[m][HALF_W-1:0]})
					* $signed({1'b0, my[m][HALF_W-1:0]});
				m_s5[m] <= (wide_t'(hh_s4[m]) <<< (2 * HALF_W))
					+ ((wide_t'(hl_s4[m]) + wide_t'(lh_s4[m])) <<< HALF_W)
					+ wide_t'(ll_s4[m]);
			end
			geo_s2 <= geo_s1;
			geo_s3 <= geo_s2;
			geo_s4 <= geo_s3;
			geo_s5 <= geo_s4;
			geo_s6 <= geo_s5;
			vc_s6 <= m_s5[0] - m_s5[1];
			vb_s6 <= m_s5[2] - m_s5[3];
			va_s6 <= m_s5[4] - m_s5[5];
		end
	end

	// region pick, tests in the usual priority order
	side_t side_n;
	wide_t n1_n, dn1_n, n2_n, dn2_n;
	dot_t  d43, d56;
	wide_t den_i;

	always_comb begin
		d43    = d_s6[3] - d_s6[2];
		d56    = d_s6[4] - d_s6[5];
		den_i  = va_s6 + vb_s6 + vc_s6;
		side_n = '0;
		side_n.pb = geo_s6.ap;
		n1_n  = '0;
		dn1_n = '0;
		n2_n  = '0;
		dn2_n = '0;
		if (d_s6[0] <= 0 && d_s6[1] <= 0) begin
			side_n.pb = geo_s6.ap;
		end else if (d_s6[2] >= 0 && d_s6[3] <= d_s6[2]) begin
			side_n.pb = geo_s6.bp;
		end else if (vc_s6 <= 0 && d_s6[0] >= 0 && d_s6[2] <= 0) begin
			side_n.e1 = geo_s6.ab;
			n1_n  = wide_t'(d_s6[0]);
			dn1_n = wide_t'(d_s6[0]) - wide_t'(d_s6[2]);
		end else if (d_s6[5] >= 0 && d_s6[4] <= d_s6[5]) begin
			side_n.pb = geo_s6.cp;
		end else if (vb_s6 <= 0 && d_s6[1] >= 0 && d_s6[5] <= 0) begin
			side_n.e1 = geo_s6.ac;
			n1_n  = wide_t'(d_s6[1]);
			dn1_n = wide_t'(d_s6[1]) - wide_t'(d_s6[5]);
		end else if (va_s6 <= 0 && d43 >= 0 && d56 >= 0) begin
			side_n.pb = geo_s6.bp;
			side_n.e1 = geo_s6.bc;
			n1_n  = wide_t'(d43);
			dn1_n = wide_t'(d43) + wide_t'(d56);
		end else if (den_i == 0) begin
			side_n.deg = 1'b1;
		end else begin
			side_n.e1 = geo_s6.ab;
			side_n.e2 = geo_s6.ac;
			n1_n  = vb_s6;
			dn1_n = den_i;
			n2_n  = vc_s6;
			dn2_n = den_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_n;
			num1_s7 <= n1_n;
			den1_s7 <= dn1_n;
			num2_s7 <= n2_n;
			den2_s7 <= dn2_n;
		end
	end

	assign out_valid = vld_s7;
	assign side      = side_s7;
	assign num1      = num1_s7;
	assign den1      = den1_s7;
	assign num2      = num2_s7;
	assign den2      = den2_s7;

	// degenerate interior falls back to vertex a with no edge terms
	a_deg_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && side_s7.deg |-> side_s7.e1 == '0 && side_s7.e2 == '0)
		else $error("degenerate word carries edge terms");

	// interior uses one shared denominator for both fractions
	a_shared_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && side_s7.e2 != '0 |-> den1_s7 == den2_s7)
		else $error("interior denominators differ");

endmodule

/* src/ptd_frac_div.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, result clamped to [0, 1.0]
// depends on ptd_pkg
module ptd_frac_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  ptd_pkg::wide_t  num,
	input  ptd_pkg::wide_t  den,
	output logic            out_valid,
	output ptd_pkg::frac_t  frac
);
	import ptd_pkg::*;

	logic [FRACTION_BITS:0]     vld_s;
	logic                       zero_s [DIV_LAT];
	logic                       one_s  [DIV_LAT];
	logic [REM_W-1:0]           rem_s  [DIV_LAT];
	logic [WIDE_W-1:0]          dnm_s  [DIV_LAT];
	logic [FRACTION_BITS-1:0]   q_s    [DIV_LAT];
	logic                       zero_n;

	assign zero_n = (den <= 0) || (num <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[FRACTION_BITS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= zero_n;
			one_s[0]  <= !zero_n && (num >= den);
			rem_s[0]  <= {1'b0, num};
			dnm_s[0]  <= den;
			q_s[0]    <= '0;
		end
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
		logic [REM_W-1:0] shl;
		logic             ge;
		assign shl = {rem_s[k-1][REM_W-2:0], 1'b0};
		assign ge  = shl >= {1'b0, dnm_s[k-1]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= ge ? shl - {1'b0, dnm_s[k-1]} : shl;
				q_s[k]    <= {q_s[k-1][FRACTION_BITS-2:0], ge};
				dnm_s[k]  <= dnm_s[k-1];
				zero_s[k] <= zero_s[k-1];
				one_s[k]  <= one_s[k-1];
			end
		end
	end

	always_comb begin
		if (zero_s[FRACTION_BITS]) begin
			frac = '0;
		end else if (one_s[FRACTION_BITS]) begin
			frac = {1'b1, {FRACTION_BITS{1'b0}}};
		end else begin
			frac = {1'b0, q_s[FRACTION_BITS]};
		end
	end

	assign out_valid = vld_s[FRACTION_BITS];

	// partial remainder stays below the divisor on the normal path
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[FRACTION_BITS] && !zero_s[FRACTION_BITS] && !one_s[FRACTION_BITS]
		|-> rem_s[FRACTION_BITS] < {1'b0, dnm_s[FRACTION_BITS]})
		else $error("divider remainder out of range");

endmodule

/* src/ptd_dist.sv */
`timescale 1ns / 1ps
// back pipeline: closest point offsets, per-axis squares, sum, scale and saturate
// depends on ptd_pkg
module ptd_dist (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  ptd_pkg::side_t  side,
	input  ptd_pkg::frac_t  f1,
	input  ptd_pkg::frac_t  f2,
	output logic            out_valid,
	output ptd_pkg::dist_t  distance,
	output logic            degenerate
);
	import ptd_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic deg_s1, deg_s2, deg_s3, deg_s4, deg_s5;
	logic signed [EF_W-1:0]  ef1_s1 [3];
	logic signed [EF_W-1:0]  ef2_s1 [3];
	diff_t                   pb_s1  [3];
	logic signed [RES_W-1:0] r_s2   [3];
	logic signed [SPP_W-1:0] hh_s3  [3];
	logic signed [SPP_W-1:0] hl_s3  [3];
	logic signed [SPP_W-1:0] ll_s3  [3];
	logic signed [SQ_W-1:0]  sq_s4  [3];
	dist_t                   dist_s5;
	logic [SUM_W-1:0]        sum_c;
	logic [SUM_W-1:0]        scaled_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		sum_c = SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		scaled_c = sum_c >> FRACTION_BITS;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				ef1_s1[i] <= side.e1[i] * $signed({1'b0, f1});
				ef2_s1[i] <= side.e2[i] * $signed({1'b0, f2});
				pb_s1[i]  <= side.pb[i];
				r_s2[i]   <= (RES_W'(pb_s1[i]) <<< FRACTION_BITS)
					- RES_W'(ef1_s1[i]) - RES_W'(ef2_s1[i]);
				// square split into high and low halves
				hh_s3[i] <= $signed(r_s2[i][RES_W-1:SQ_LO_W]) * $signed(r_s2[i][RES_W-1:SQ_LO_W]);
				hl_s3[i] <= $signed(r_s2[i][RES_W-1:SQ_LO_W])
					* $signed({1'b0, r_s2[i][SQ_LO_W-1:0]});
				ll_s3[i] <= $signed({1'b0, r_s2[i][SQ_LO_W-1:0]})
					* $signed({1'b0, r_s2[i][SQ_LO_W-1:0]});
				sq_s4[i] <= (SQ_W'(hh_s3[i]) <<< (2 * SQ_LO_W))
					+ (SQ_W'(hl_s3[i]) <<< (SQ_LO_W + 1)) + SQ_W'(ll_s3[i]);
			end
			deg_s1 <= side.deg;
			deg_s2 <= deg_s1;
			deg_s3 <= deg_s2;
			deg_s4 <= deg_s3;
			deg_s5 <= deg_s4;
			dist_s5 <= (scaled_c > SUM_W'(DIST_MAX)) ? DIST_MAX : scaled_c[DIST_W-1:0];
		end
	end

	assign out_valid  = vld_s5;
	assign distance   = dist_s5;
	assign degenerate = deg_s5;

endmodule

/* src/point_triangle_distance_unit.sv */
`timescale 1ns / 1ps
// top level of the point to triangle squared distance pipeline
// depends on ptd_pkg, ptd_query_if, ptd_result_if, ptd_region, ptd_frac_div, ptd_dist
//
//  channel  dir  word                                        handshake
//  query    in   point p, vertices a b c, 16-bit signed xyz  valid/ready
//  result   out  distance_squared (50b, 16 frac), degenerate valid/ready
//
// one word in and one word out per cycle while results are taken;
// the divider's one-quotient-bit-per-stage chain sets most of the
// pipeline depth
// all stages move on one shared enable; the last stage is the output register,
// so a stalled result freezes the pipe in place and nothing is dropped or doubled
// reset clears the valid bits only, payload registers are not reset;
// query ready is held low while reset is asserted
module point_triangle_distance_unit (
	input logic          clk,
	input logic          arst_n,
	ptd_query_if.sink    query,
	ptd_result_if.source result
);
	import ptd_pkg::*;

	// pipeline advances whenever the output register is empty or being taken
	logic adv;
	assign adv = !result.valid || result.ready;
	assign query.ready = adv && arst_n;

	coord_t [2:0] p, a, b, c;
	assign p = {query.query_z, query.query_y, query.query_x};
	assign a = {query.vert_a_z, query.vert_a_y, query.vert_a_x};
	assign b = {query.vert_b_z, query.vert_b_y, query.vert_b_x};
	assign c = {query.vert_c_z, query.vert_c_y, query.vert_c_x};

	logic  rg_valid;
	side_t rg_side;
	wide_t num1, den1, num2, den2;

	// dot products, region determinants and region choice
	ptd_region u_region (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (query.valid),
		.p         (p),
		.a         (a),
		.b         (b),
		.c         (c),
		.out_valid (rg_valid),
		.side      (rg_side),
		.num1      (num1),
		.den1      (den1),
		.num2      (num2),
		.den2      (den2)
	);

	logic  dv1_valid, dv2_valid;
	frac_t f1, f2;

	// two dividers side by side, the interior case needs both fractions
	ptd_frac_div u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rg_valid),
		.num       (num1),
		.den       (den1),
		.out_valid (dv1_valid),
		.frac      (f1)
	);

	ptd_frac_div u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rg_valid),
		.num       (num2),
		.den       (den2),
		.out_valid (dv2_valid),
		.frac      (f2)
	);

	// side data rides alongside the divider stages
	side_t side_dly_s [DIV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dly_s[0] <= rg_side;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_dly_s[k] <= side_dly_s[k-1];
			end
		end
	end

	// closest point offset, squares, sum and saturation
	ptd_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (dv1_valid),
		.side       (side_dly_s[DIV_LAT-1]),
		.f1         (f1),
		.f2         (f2),
		.out_valid  (result.valid),
		.distance   (result.distance_squared),
		.degenerate (result.degenerate)
	);

	// both dividers run in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dv1_valid == dv2_valid)
		else $error("divider valid bits out of step");

endmodule

/* tb/tb_point_triangle_distance_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench of the point to triangle squared distance unit
// depends on ptd_pkg, ptd_query_if, ptd_result_if and point_triangle_distance_unit
module tb_point_triangle_distance_unit;
	import ptd_pkg::*;

	localparam int N_RANDOM   = 630;
	localparam int LATENCY    = 29;
	localparam int STALL_MAX  = 2000;

	typedef struct {
		logic signed [COORD_BITS-1:0] c [12];
	} query_word_t;

	typedef struct {
		dist_t dsq;
		logic  deg;
	} dist_word_t;

	// directed row: coordinates, and a typed-in result where it is obvious
	typedef struct {
		int          c [12];
		bit          known;
		longint      dsq;
		bit          deg;
	} row_t;

	logic clk;
	logic arst_n;

	ptd_query_if  query();
	ptd_result_if result();

	point_triangle_distance_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query.sink),
		.result (result.source)
	);

	dist_word_t  pending_dist [$];
	int          n_errors;
	int          n_accepted;
	int          n_checked;
	int          n_degenerate;
	int          idle_in_pct;
	int          idle_out_pct;
	int          stall_cycles = 0;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------------
	// predictor: 128-bit signed math stands in for the block's wide datapath
	// ---------------------------------------------------------------------
	function automatic longint clamp_frac(logic signed [127:0] num,
		logic signed [127:0] den);
		logic signed [127:0] r;
		longint q;
		q = 0;
		if (den <= 0 || num <= 0)
			return 0;
		if (num >= den)
			return longint'(1) << FRACTION_BITS;
		r = num;
		// restoring long division, one quotient bit per step
		for (int i = 0; i < FRACTION_BITS; i++) begin
			r = r <<< 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic dist_word_t closest_distance(query_word_t w);
		longint p [3], a [3], b [3], c [3];
		longint ab [3], ac [3], bc [3], ap [3], bp [3], cp [3];
		longint base [3], e1 [3], e2 [3];
		longint f1, f2, d1, d2, d3, d4, d5, d6, d;
		logic signed [127:0] va, vb, vc, den, sum;
		dist_word_t r;
		f1 = 0;
		f2 = 0;
		r.deg = 1'b0;
		for (int i = 0; i < 3; i++) begin
			p[i] = w.c[i];
			a[i] = w.c[3 + i];
			b[i] = w.c[6 + i];
			c[i] = w.c[9 + i];
			ab[i] = b[i] - a[i];
			ac[i] = c[i] - a[i];
			bc[i] = c[i] - b[i];
			ap[i] = p[i] - a[i];
			bp[i] = p[i] - b[i];
			cp[i] = p[i] - c[i];
			base[i] = a[i];
			e1[i] = 0;
			e2[i] = 0;
		end
		d1 = ab[0] * ap[0] + ab[1] * ap[1] + ab[2] * ap[2];
		d2 = ac[0] * ap[0] + ac[1] * ap[1] + ac[2] * ap[2];
		d3 = ab[0] * bp[0] + ab[1] * bp[1] + ab[2] * bp[2];
		d4 = ac[0] * bp[0] + ac[1] * bp[1] + ac[2] * bp[2];
		d5 = ab[0] * cp[0] + ab[1] * cp[1] + ab[2] * cp[2];
		d6 = ac[0] * cp[0] + ac[1] * cp[1] + ac[2] * cp[2];
		vc = 128'(d1) * 128'(d4) - 128'(d3) * 128'(d2);
		vb = 128'(d5) * 128'(d2) - 128'(d1) * 128'(d6);
		va = 128'(d3) * 128'(d6) - 128'(d5) * 128'(d4);

		if (d1 <= 0 && d2 <= 0) begin
			// vertex a region, base already a
		end else if (d3 >= 0 && d4 <= d3) begin
			base = b;
		end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			e1 = ab;
			f1 = clamp_frac(128'(d1), 128'(d1 - d3));
		end else if (d6 >= 0 && d5 <= d6) begin
			base = c;
		end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			e1 = ac;
			f1 = clamp_frac(128'(d2), 128'(d2 - d6));
		end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
			base = b;
			e1 = bc;
			f1 = clamp_frac(128'(d4 - d3), 128'((d4 - d3) + (d5 - d6)));
		end else begin
			den = va + vb + vc;
			if (den == 0) begin
				// flat triangle: fall back to vertex a
				r.deg = 1'b1;
			end else begin
				e1 = ab;
				f1 = clamp_frac(vb, den);
				e2 = ac;
				f2 = clamp_frac(vc, den);
			end
		end

		sum = 0;
		for (int i = 0; i < 3; i++) begin
			d = (p[i] - base[i]) * (longint'(1) << FRACTION_BITS) - e1[i] * f1 - e2[i] * f2;
			sum = sum + 128'(d) * 128'(d);
		end
		sum = sum >>> FRACTION_BITS;
		r.dsq = (sum > 128'(DIST_MAX)) ? DIST_MAX : dist_t'(sum);
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// query driver, changes at the falling edge; valid stays up between
	// back-to-back words and the caller drops it after the last one
	// ---------------------------------------------------------------------
	task automatic put_query(query_word_t w);
		while (($urandom_range(99) < idle_in_pct)) begin
			query.valid <= 1'b0;
			@(negedge clk);
		end
		query.valid    <= 1'b1;
		query.query_x  <= w.c[0];
		query.query_y  <= w.c[1];
		query.query_z  <= w.c[2];
		query.vert_a_x <= w.c[3];
		query.vert_a_y <= w.c[4];
		query.vert_a_z <= w.c[5];
		query.vert_b_x <= w.c[6];
		query.vert_b_y <= w.c[7];
		query.vert_b_z <= w.c[8];
		query.vert_c_x <= w.c[9];
		query.vert_c_y <= w.c[10];
		query.vert_c_z <= w.c[11];
		// hold until the word is taken at a rising edge
		do
			@(posedge clk);
		while (!query.ready);
		pending_dist = {pending_dist, closest_distance(w)};
		n_accepted++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------
	// result monitor and scoreboard, sampled at the rising edge
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		dist_word_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_dist.size() == 0) begin
				$error("unexpected result word: distance_squared=%0d degenerate=%0b",
					result.distance_squared, result.degenerate);
				n_errors++;
			end else begin
				want = pending_dist.pop_front();
				if (result.distance_squared !== want.dsq) begin
					$error("distance_squared: expected %0d, actual %0d",
						want.dsq, result.distance_squared);
					n_errors++;
				end
				if (result.degenerate !== want.deg) begin
					$error("degenerate: expected %0b, actual %0b",
						want.deg, result.degenerate);
					n_errors++;
				end
				if (want.deg)
					n_degenerate++;
				n_checked++;
			end
		end
	end

	// receiver backpressure, drawn at the falling edge
	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= idle_out_pct);
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_MAX) begin
			$display("point_triangle_distance_unit verification failed");
			$finish;
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rand_coord(int span);
		if (span == 0)
			return COORD_BITS'($urandom);
		return COORD_BITS'($urandom_range(2 * span) - span);
	endfunction

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------
	initial begin
		row_t        dir_rows [$];
		row_t        row;
		query_word_t w;
		query_word_t tri_w;
		dist_word_t  pred;
		int          span;
		int          kind;

		arst_n       = 1'b0;
		query.valid  = 1'b0;
		query.query_x = '0; query.query_y = '0; query.query_z = '0;
		query.vert_a_x = '0; query.vert_a_y = '0; query.vert_a_z = '0;
		query.vert_b_x = '0; query.vert_b_y = '0; query.vert_b_z = '0;
		query.vert_c_x = '0; query.vert_c_y = '0; query.vert_c_z = '0;
		result.ready = 1'b0;
		n_errors     = 0;
		n_accepted   = 0;
		n_checked    = 0;
		n_degenerate = 0;
		idle_in_pct  = 0;
		idle_out_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows: p, a, b, c; typed-in results where obvious
		// all zero: collapsed triangle, but the vertex a test catches it first
		dir_rows = {dir_rows, row_t'{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, 0, 0}};
		// point sitting on vertex a of a proper triangle
		dir_rows = {dir_rows, row_t'{'{0,0,0, 0,0,0, 100,0,0, 0,100,0}, 1, 0, 0}};
		// behind vertex a: distance to a, 1 unit squared
		dir_rows = {dir_rows, row_t'{'{-1,0,0, 0,0,0, 100,0,0, 0,100,0}, 1, 65536, 0}};
		// beyond vertex b and c
		dir_rows = {dir_rows, row_t'{'{102,0,0, 0,0,0, 100,0,0, 0,100,0}, 1, 4*65536, 0}};
		dir_rows = {dir_rows, row_t'{'{0,103,0, 0,0,0, 100,0,0, 0,100,0}, 1, 9*65536, 0}};
		// above the interior, 5 units off the plane
		dir_rows = {dir_rows, row_t'{'{10,10,5, 0,0,0, 100,0,0, 0,100,0}, 1, 25*65536, 0}};
		// beside edge ab, ac and bc
		dir_rows = {dir_rows, row_t'{'{50,-3,0, 0,0,0, 100,0,0, 0,100,0}, 1, 9*65536, 0}};
		dir_rows = {dir_rows, row_t'{'{-4,50,0, 0,0,0, 100,0,0, 0,100,0}, 1, 16*65536, 0}};
		dir_rows = {dir_rows, row_t'{'{60,60,0, 0,0,0, 100,0,0, 0,100,0}, 0, 0, 0}};
		// zero-length edges: a equals b, and all vertices equal
		dir_rows = {dir_rows, row_t'{'{7,7,7, 1,1,1, 1,1,1, 9,2,3}, 0, 0, 0}};
		dir_rows = {dir_rows, row_t'{'{3,0,0, 1,1,1, 1,1,1, 1,1,1}, 0, 0, 0}};
		// collinear vertices with the point alongside: flat triangle
		dir_rows = {dir_rows, row_t'{'{5,5,0, 0,0,0, 10,0,0, 20,0,0}, 0, 0, 0}};
		dir_rows = {dir_rows, row_t'{'{15,-2,4, 0,0,0, 10,0,0, 20,0,0}, 0, 0, 0}};
		// coordinate extremes, largest distances
		dir_rows = {dir_rows, row_t'{'{32767,32767,32767, -32768,-32768,-32768,
			-32768,-32768,-32768, -32768,-32768,-32768}, 0, 0, 0}};
		dir_rows = {dir_rows, row_t'{'{-32768,-32768,-32768, 32767,32767,32767,
			32767,-32768,32767, -32768,32767,32767}, 0, 0, 0}};
		dir_rows = {dir_rows, row_t'{'{-1,-1,-1, 32767,-32768,32767,
			-32768,32767,-32768, 32767,32767,-32768}, 0, 0, 0}};
		dir_rows = {dir_rows, row_t'{'{0,0,32767, -32768,-32768,0,
			32767,-32768,0, 0,32767,0}, 0, 0, 0}};
		// non-trivial interior fractions
		dir_rows = {dir_rows, row_t'{'{33,21,-9, 0,0,0, 97,13,0, 7,89,11}, 0, 0, 0}};

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			for (int k = 0; k < 12; k++)
				w.c[k] = COORD_BITS'(row.c[k]);
			if (row.known) begin
				pred = closest_distance(w);
				if (pred.dsq != dist_t'(row.dsq) || pred.deg != row.deg) begin
					$error("directed row %0d: typed-in result disagrees with prediction", i);
					n_errors++;
				end
			end
			put_query(w);
		end
		query.valid <= 1'b0;

		// hold off until the pipe drains once
		wait (pending_dist.size() == 0);
		@(negedge clk);

		// random part in three idling phases
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 0) begin
				idle_in_pct = 32; idle_out_pct = 70;
			end else if (n == N_RANDOM / 3) begin
				idle_in_pct = 70; idle_out_pct = 32;
			end else if (n == 2 * N_RANDOM / 3) begin
				idle_in_pct = 0; idle_out_pct = 0;
			end
			kind = $urandom_range(9);
			// mostly small shapes so every region is hit, a few full-range
			span = (kind < 3) ? 64 : (kind < 6) ? 2000 : (kind < 9) ? 0 : 16;
			for (int k = 0; k < 12; k++)
				w.c[k] = rand_coord(span);
			if (kind == 9) begin
				// collinear or repeated vertices: c sits at a + 2 (b - a)
				tri_w = w;
				for (int k = 0; k < 3; k++) begin
					w.c[9 + k] = COORD_BITS'(tri_w.c[3 + k]
						+ 2 * (tri_w.c[6 + k] - tri_w.c[3 + k]));
				end
				if ($urandom_range(1))
					for (int k = 0; k < 3; k++)
						w.c[6 + k] = w.c[3 + k];
			end
			put_query(w);
		end
		query.valid <= 1'b0;

		wait (pending_dist.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);

		$display("covered %0d query words, %0d results checked, %0d flat triangles",
			n_accepted, n_checked, n_degenerate);
		if (n_errors == 0 && pending_dist.size() == 0)
			$display("point_triangle_distance_unit verification clean");
		else
			$display("point_triangle_distance_unit verification failed");
		$finish;
	end

endmodule

/* point_triangle_distance_unit.f */
src/ptd_pkg.sv
src/ptd_query_if.sv
src/ptd_result_if.sv
src/ptd_region.sv
src/ptd_frac_div.sv
src/ptd_dist.sv
src/point_triangle_distance_unit.sv
tb/tb_point_triangle_distance_unit.sv
